>>> rtl/armc_pkg.sv
// ----------------------------------------------------------------------------
// armc_pkg: shared types, codes and fixed-point helpers
// Register map, control law codes, the item carried down the pipeline and the
// round/saturate functions used by the arithmetic stages.
// ----------------------------------------------------------------------------
package armc_pkg;

    localparam int ADDR_W = 5;
    localparam int I_SH   = 30;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_IXX  = 3'd1,
        REG_IYY  = 3'd2,
        REG_IZZ  = 3'd3,
        REG_IXY  = 3'd4,
        REG_IXZ  = 3'd5,
        REG_IYZ  = 3'd6,
        REG_GAIN = 3'd7
    } armc_reg_t;

    typedef enum logic [1:0] {
        LAW_NONE = 2'd0,
        LAW_PROP = 2'd1,
        LAW_LIN  = 2'd2,
        LAW_TWO  = 2'd3
    } armc_law_t;

    typedef struct packed {
        logic signed [2:0]  mode;
        logic signed [31:0] ixx;
        logic signed [31:0] iyy;
        logic signed [31:0] izz;
        logic signed [31:0] ixy;
        logic signed [31:0] ixz;
        logic signed [31:0] iyz;
        logic        [31:0] gain;
    } armc_cfg_t;

    // item state that rides along the divider and the pitch tail
    typedef struct packed {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic signed [31:0] q;
        logic signed [31:0] pz;
        armc_law_t          law;
        logic               stg;
        logic               sgn;
        logic               full;
    } armc_carry_t;

    function automatic logic signed [67:0] mul32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        mul32 = 68'(a) * 68'(b);
    endfunction

    function automatic logic [32:0] abs33(input logic signed [31:0] v);
        logic signed [32:0] x;
        x = 33'(v);
        abs33 = x[32] ? 33'(-x) : 33'(x);
    endfunction

    // round to nearest, halves away from zero
    function automatic logic signed [67:0] rnd(input logic signed [67:0] p,
                                               input int sh);
        logic [67:0] m;
        m = p[67] ? 68'(-p) : 68'(p);
        m = (m + (68'd1 << (sh - 1))) >> sh;
        rnd = p[67] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sh7FFFFFFF)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -68'sh80000000)
            sat32 = -32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [31:0] rsat(input logic signed [67:0] p,
                                                input int sh);
        rsat = sat32(rnd(p, sh));
    endfunction

endpackage

>>> rtl/armc_cfg.sv
// ----------------------------------------------------------------------------
// armc_cfg: configuration register file
// APB-style write and read of mode, inertia tensor and pwm gain.
// ----------------------------------------------------------------------------
module armc_cfg
    import armc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output armc_cfg_t         cfg
);

    armc_cfg_t cfg_reg;
    armc_reg_t idx;
    logic      wr;

    assign pready = 1'b1;
    assign idx    = armc_reg_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MODE: cfg_reg.mode <= pwdata[2:0];
                REG_IXX:  cfg_reg.ixx  <= pwdata;
                REG_IYY:  cfg_reg.iyy  <= pwdata;
                REG_IZZ:  cfg_reg.izz  <= pwdata;
                REG_IXY:  cfg_reg.ixy  <= pwdata;
                REG_IXZ:  cfg_reg.ixz  <= pwdata;
                REG_IYZ:  cfg_reg.iyz  <= pwdata;
                REG_GAIN: cfg_reg.gain <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE: prdata = 32'(cfg_reg.mode);
            REG_IXX:  prdata = cfg_reg.ixx;
            REG_IYY:  prdata = cfg_reg.iyy;
            REG_IZZ:  prdata = cfg_reg.izz;
            REG_IXY:  prdata = cfg_reg.ixy;
            REG_IXZ:  prdata = cfg_reg.ixz;
            REG_IYZ:  prdata = cfg_reg.iyz;
            REG_GAIN: prdata = cfg_reg.gain;
        endcase
    end

endmodule

>>> rtl/armc_div.sv
// ----------------------------------------------------------------------------
// armc_div: pipelined restoring divider
// One quotient bit per stage; remainder starts below the divisor, so the
// quotient is a pure fraction of DEPTH bits.
// ----------------------------------------------------------------------------
module armc_div
    import armc_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  logic [DEPTH-1:0] en,
    input  logic [31:0]      rem_in,
    input  logic [31:0]      dvs_in,
    input  armc_carry_t      carry_in,
    output logic [DEPTH-1:0] quo_out,
    output armc_carry_t      carry_out
);

    logic [31:0]      rem_reg   [DEPTH];
    logic [31:0]      dvs_reg   [DEPTH];
    logic [DEPTH-1:0] quo_reg   [DEPTH];
    armc_carry_t      carry_reg [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_step
        logic [31:0]      rem_src;
        logic [31:0]      dvs_src;
        logic [DEPTH-1:0] quo_src;
        armc_carry_t      carry_src;
        logic [32:0]      shl;
        logic             ge;
        logic [31:0]      rem_next;

        if (i == 0)
        begin : g_first
            assign rem_src   = rem_in;
            assign dvs_src   = dvs_in;
            assign quo_src   = '0;
            assign carry_src = carry_in;
        end
        else
        begin : g_next
            assign rem_src   = rem_reg[i-1];
            assign dvs_src   = dvs_reg[i-1];
            assign quo_src   = quo_reg[i-1];
            assign carry_src = carry_reg[i-1];
        end

        assign shl      = {rem_src, 1'b0};
        assign ge       = shl >= {1'b0, dvs_src};
        assign rem_next = ge ? 32'(shl - {1'b0, dvs_src}) : shl[31:0];

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                rem_reg[i]   <= rem_next;
                dvs_reg[i]   <= dvs_src;
                quo_reg[i]   <= {quo_src[DEPTH-2:0], ge};
                carry_reg[i] <= carry_src;
            end
        end
    end

    assign quo_out   = quo_reg[DEPTH-1];
    assign carry_out = carry_reg[DEPTH-1];

endmodule

>>> rtl/armc_scale.sv
// ----------------------------------------------------------------------------
// armc_scale: moment to pulse width
// Multiplies a clamped moment by the pwm gain, rounds, adds stick middle and
// saturates to 16 bits. Two register stages.
// ----------------------------------------------------------------------------
module armc_scale
    import armc_pkg::*;
#(
    parameter int PWM_CENTER = 1500,
    parameter int FRAC_BITS  = 16
)
(
    input  logic               clk,
    input  logic [1:0]         en,
    input  logic signed [31:0] mom,
    input  logic [31:0]        gain,
    output logic [15:0]        pwm
);

    logic signed [67:0] prod_reg;
    logic signed [67:0] sum;
    logic [15:0]        pwm_reg;
    logic [15:0]        pwm_next;

    assign sum = rnd(prod_reg, 2 * FRAC_BITS) + 68'(PWM_CENTER);

    always_comb
    begin
        priority if (sum < 68'sd0)
            pwm_next = 16'h0000;
        else if (sum > 68'sd65535)
            pwm_next = 16'hFFFF;
        else
            pwm_next = sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= 68'(mom) * $signed(68'(gain));
        end
        if (en[1])
        begin
            pwm_reg <= pwm_next;
        end
    end

    assign pwm = pwm_reg;

endmodule

>>> rtl/attitude_rate_moment_controller_top.sv
// ----------------------------------------------------------------------------
// attitude_rate_moment_controller_top: body rate moment controller
// Gyro sample plus autopilot switch in, three actuator pulse widths out.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid/sample_stall) carries one gyro item: rates
//   p, q, r and the autopilot switch pulse width. Result channel
//   (result_valid/result_stall) returns one item per sample, in order.
//   Configuration is written over the APB port while the block is idle.
//   The pipeline depth is set by the one-bit-per-stage quotient divider
//   of the two-stage law and the multiply/round stage pairs around it.
//   Throughput is one item per cycle while result_stall stays low.
//   Each stage holds its item while the stage after it is full and cannot
//   move, so a stalled result still lets upstream bubbles fill; sample_stall
//   rises only when every stage holds an item.
//   Reset clears all valid bits and the configuration registers (law 0,
//   every channel at stick middle). No clearing pass is needed.
// ----------------------------------------------------------------------------
module attitude_rate_moment_controller_top
    import armc_pkg::*;
#(
    parameter int PWM_CENTER = 1500,
    parameter int FRAC_BITS  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic [15:0]       autopilot_pwm,
    input  logic signed [31:0] rate_p,
    input  logic signed [31:0] rate_q,
    input  logic signed [31:0] rate_r,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [15:0]       pwm_roll,
    output logic [15:0]       pwm_pitch,
    output logic [15:0]       pwm_yaw,
    output logic [1:0]        mode_used,
    output logic              detumble_stage
);

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint K1P = (6 * ONE + 5) / 10;
    localparam longint K1Q = (55 * ONE + 50) / 100;
    localparam longint K2P = 5 * ONE;
    localparam longint K2Q = (13 * ONE + 1) / 2;
    localparam longint K2R = 12 * ONE;
    localparam longint K3P = 4 * ONE;
    localparam longint K3Q = 2 * ONE;
    localparam longint THR = (9 * ONE + 500) / 1000;
    localparam longint PC  = (ONE + 1) / 2;
    localparam longint LIM = (ONE + 5) / 10;

    localparam logic signed [31:0] NK1P  = 32'(-K1P);
    localparam logic signed [31:0] NK1Q  = 32'(-K1Q);
    localparam logic signed [31:0] NK2P  = 32'(-K2P);
    localparam logic signed [31:0] NK2Q  = 32'(-K2Q);
    localparam logic signed [31:0] NK2R  = 32'(-K2R);
    localparam logic signed [31:0] NK3P  = 32'(-K3P);
    localparam logic signed [31:0] NK3Q  = 32'(-K3Q);
    localparam logic signed [31:0] LIM32 = 32'(LIM);

    localparam int NDIV   = FRAC_BITS;
    localparam int ST_S5  = 4;
    localparam int ST_E   = 5 + NDIV;
    localparam int ST_X3  = 6 + NDIV;
    localparam int ST_R3  = 7 + NDIV;
    localparam int ST_X4  = 8 + NDIV;
    localparam int ST_R4  = 9 + NDIV;
    localparam int ST_XP  = 10 + NDIV;
    localparam int ST_OUT = 11 + NDIV;
    localparam int NST    = 12 + NDIV;

    armc_cfg_t cfg;

    armc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- pipeline control ----------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;

    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || !result_stall;
        for (int s = NST - 2; s >= 0; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
                vld_reg[0] <= sample_valid;
            for (int s = 1; s < NST; s++)
                if (adv[s])
                    vld_reg[s] <= vld_reg[s-1];
        end
    end

    assign sample_stall = !adv[0];
    assign result_valid = vld_reg[NST-1];

    // ---------------- config-derived terms ----------------
    logic signed [31:0] dxy, dyz, dzx;
    logic signed [31:0] im [3][3];

    assign dxy = sat32(68'(cfg.ixx) - 68'(cfg.iyy));
    assign dyz = sat32(68'(cfg.iyy) - 68'(cfg.izz));
    assign dzx = sat32(68'(cfg.izz) - 68'(cfg.ixx));

    always_comb
    begin
        im[0][0] = cfg.ixx; im[0][1] = cfg.ixy; im[0][2] = cfg.ixz;
        im[1][0] = cfg.ixy; im[1][1] = cfg.iyy; im[1][2] = cfg.iyz;
        im[2][0] = cfg.ixz; im[2][1] = cfg.iyz; im[2][2] = cfg.izz;
    end

    // ---------------- S1: capture, law select ----------------
    logic [2:0]         sel;
    armc_law_t          law_next;
    logic               stg_next;
    logic signed [31:0] ep_next, nr_next;

    always_comb
    begin
        if (cfg.mode < 0)
            sel = (autopilot_pwm > 16'(PWM_CENTER)) ? 3'(-cfg.mode) : 3'd0;
        else
            sel = cfg.mode;
        law_next = (sel > 3'd3) ? LAW_NONE : armc_law_t'(sel[1:0]);
        stg_next = (law_next == LAW_TWO)
                && (abs33(rate_q) > 33'(THR) || abs33(rate_r) > 33'(THR));
        ep_next  = sat32(68'(rate_p) - (stg_next ? 68'(PC) : 68'sd0));
        nr_next  = sat32(-68'(rate_r));
    end

    logic signed [31:0] w1_reg [3];
    armc_law_t          law1_reg;
    logic               stg1_reg;
    logic signed [31:0] ep1_reg, nr1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            w1_reg[0] <= rate_p;
            w1_reg[1] <= rate_q;
            w1_reg[2] <= rate_r;
            law1_reg  <= law_next;
            stg1_reg  <= stg_next;
            ep1_reg   <= ep_next;
            nr1_reg   <= nr_next;
        end
    end

    // ---------------- S2: first products ----------------
    logic signed [31:0] kc [3];

    always_comb
    begin
        kc[0] = (law1_reg == LAW_PROP) ? NK1P : NK2P;
        kc[1] = (law1_reg == LAW_PROP) ? NK1Q : NK2Q;
        kc[2] = (law1_reg == LAW_PROP) ? NK1Q : NK2R;
    end

    logic signed [67:0] kw2_reg [3];
    logic signed [67:0] iwp2_reg [3][3];
    logic signed [67:0] qr2_reg, pr2_reg, a3p2_reg, nump2_reg, denp2_reg;
    logic signed [31:0] w2_reg [3];
    armc_law_t          law2_reg;
    logic               stg2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                kw2_reg[k] <= mul32(kc[k], w1_reg[k]);
                for (int j = 0; j < 3; j++)
                    iwp2_reg[k][j] <= mul32(im[k][j], w1_reg[j]);
                w2_reg[k] <= w1_reg[k];
            end
            qr2_reg   <= mul32(w1_reg[1], w1_reg[2]);
            pr2_reg   <= mul32(w1_reg[0], w1_reg[2]);
            a3p2_reg  <= mul32(NK3P, ep1_reg);
            nump2_reg <= mul32(cfg.izz, nr1_reg);
            denp2_reg <= mul32(w1_reg[0], dxy);
            law2_reg  <= law1_reg;
            stg2_reg  <= stg1_reg;
        end
    end

    // ---------------- S3: round first products ----------------
    logic signed [31:0] kg3_reg [3];
    logic signed [31:0] iw3_reg [3];
    logic signed [31:0] qr3_reg, pr3_reg, a33_reg, num3_reg, den3_reg;
    logic signed [31:0] w3_reg [3];
    armc_law_t          law3_reg;
    logic               stg3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                kg3_reg[k] <= rsat(kw2_reg[k], FRAC_BITS);
                iw3_reg[k] <= sat32(68'(rsat(iwp2_reg[k][0], I_SH))
                                  + 68'(rsat(iwp2_reg[k][1], I_SH))
                                  + 68'(rsat(iwp2_reg[k][2], I_SH)));
                w3_reg[k]  <= w2_reg[k];
            end
            qr3_reg  <= rsat(qr2_reg, FRAC_BITS);
            pr3_reg  <= rsat(pr2_reg, FRAC_BITS);
            a33_reg  <= rsat(a3p2_reg, FRAC_BITS);
            num3_reg <= rsat(nump2_reg, I_SH);
            den3_reg <= rsat(denp2_reg, I_SH);
            law3_reg <= law2_reg;
            stg3_reg <= stg2_reg;
        end
    end

    // ---------------- S4: second products ----------------
    logic signed [67:0] igp4_reg [3][3];
    logic signed [67:0] cra4_reg [3];
    logic signed [67:0] crb4_reg [3];
    logic signed [67:0] rxa4_reg, rxb4_reg, pzp4_reg;
    logic signed [31:0] kg4_reg [3];
    logic signed [31:0] num4_reg, den4_reg, q4_reg;
    armc_law_t          law4_reg;
    logic               stg4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                    igp4_reg[k][j] <= mul32(im[k][j], kg3_reg[j]);
                kg4_reg[k] <= kg3_reg[k];
            end
            // omega cross (I omega)
            cra4_reg[0] <= mul32(w3_reg[1], iw3_reg[2]);
            crb4_reg[0] <= mul32(w3_reg[2], iw3_reg[1]);
            cra4_reg[1] <= mul32(w3_reg[2], iw3_reg[0]);
            crb4_reg[1] <= mul32(w3_reg[0], iw3_reg[2]);
            cra4_reg[2] <= mul32(w3_reg[0], iw3_reg[1]);
            crb4_reg[2] <= mul32(w3_reg[1], iw3_reg[0]);
            rxa4_reg    <= mul32(cfg.ixx, a33_reg);
            rxb4_reg    <= mul32(dyz, qr3_reg);
            pzp4_reg    <= mul32(dzx, pr3_reg);
            num4_reg    <= num3_reg;
            den4_reg    <= den3_reg;
            q4_reg      <= w3_reg[1];
            law4_reg    <= law3_reg;
            stg4_reg    <= stg3_reg;
        end
    end

    // ---------------- S5: moments, divider setup ----------------
    logic signed [31:0] m2 [3];
    logic signed [31:0] ig, cr, m3x;
    logic [32:0]        un, ud;
    logic               den_zero;
    armc_carry_t        carry_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ig = sat32(68'(rsat(igp4_reg[k][0], I_SH))
                     + 68'(rsat(igp4_reg[k][1], I_SH))
                     + 68'(rsat(igp4_reg[k][2], I_SH)));
            cr = sat32(68'(rsat(cra4_reg[k], FRAC_BITS))
                     - 68'(rsat(crb4_reg[k], FRAC_BITS)));
            m2[k] = sat32(68'(ig) + 68'(cr));
        end
        m3x = sat32(68'(rsat(rxa4_reg, I_SH)) - 68'(rsat(rxb4_reg, I_SH)));

        carry_next.mx = '0;
        carry_next.my = '0;
        carry_next.mz = '0;
        unique case (law4_reg)
            LAW_NONE: ;
            LAW_PROP:
            begin
                carry_next.mx = kg4_reg[0];
                carry_next.my = kg4_reg[1];
                carry_next.mz = kg4_reg[2];
            end
            LAW_LIN:
            begin
                carry_next.mx = m2[0];
                carry_next.my = m2[1];
                carry_next.mz = m2[2];
            end
            LAW_TWO:  carry_next.mx = m3x;
        endcase
        carry_next.q   = q4_reg;
        carry_next.pz  = rsat(pzp4_reg, I_SH);
        carry_next.law = law4_reg;
        carry_next.stg = stg4_reg;

        // pitch command: zero divisor or |num| >= |den| saturates to one
        un       = abs33(num4_reg);
        ud       = abs33(den4_reg);
        den_zero = (den4_reg == 32'sd0);
        carry_next.sgn  = den_zero ? num4_reg[31] : (num4_reg[31] ^ den4_reg[31]);
        carry_next.full = den_zero || (un >= ud);
    end

    armc_carry_t carry5_reg;
    logic [31:0] rem5_reg, dvs5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_S5])
        begin
            carry5_reg <= carry_next;
            rem5_reg   <= un[31:0];
            dvs5_reg   <= ud[31:0];
        end
    end

    // ---------------- divider ----------------
    logic [NDIV-1:0] quo_d;
    armc_carry_t     carry_d;

    armc_div #(
        .DEPTH (NDIV)
    ) u_div (
        .clk       (clk),
        .en        (adv[ST_S5+1 +: NDIV]),
        .rem_in    (rem5_reg),
        .dvs_in    (dvs5_reg),
        .carry_in  (carry5_reg),
        .quo_out   (quo_d),
        .carry_out (carry_d)
    );

    // ---------------- pitch tail ----------------
    logic [32:0]        qmag;
    logic signed [32:0] qc;

    always_comb
    begin
        qmag = carry_d.full ? 33'(ONE) : 33'(quo_d);
        if (!carry_d.stg)
            qc = '0;
        else if (carry_d.sgn)
            qc = -$signed(qmag);
        else
            qc = $signed(qmag);
    end

    logic signed [31:0] eq6_reg, b8_reg;
    logic signed [67:0] bp7_reg, yp9_reg;
    armc_carry_t        carry6_reg, carry7_reg, carry8_reg, carry9_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_E])
        begin
            eq6_reg    <= sat32(68'(carry_d.q) - 68'(qc));
            carry6_reg <= carry_d;
        end
        if (adv[ST_X3])
        begin
            bp7_reg    <= mul32(NK3Q, eq6_reg);
            carry7_reg <= carry6_reg;
        end
        if (adv[ST_R3])
        begin
            b8_reg     <= rsat(bp7_reg, FRAC_BITS);
            carry8_reg <= carry7_reg;
        end
        if (adv[ST_X4])
        begin
            yp9_reg    <= mul32(cfg.iyy, b8_reg);
            carry9_reg <= carry8_reg;
        end
    end

    // ---------------- R4: final pitch, clamp ----------------
    logic signed [31:0] msel [3];
    logic signed [31:0] mc_next [3];

    always_comb
    begin
        msel[0] = carry9_reg.mx;
        msel[1] = (carry9_reg.law == LAW_TWO)
                ? sat32(68'(rsat(yp9_reg, I_SH)) - 68'(carry9_reg.pz))
                : carry9_reg.my;
        msel[2] = carry9_reg.mz;
        for (int k = 0; k < 3; k++)
        begin
            priority if (msel[k] > LIM32)
                mc_next[k] = LIM32;
            else if (msel[k] < -LIM32)
                mc_next[k] = -LIM32;
            else
                mc_next[k] = msel[k];
        end
    end

    logic signed [31:0] mc10_reg [3];
    armc_law_t          law10_reg, law11_reg, law12_reg;
    logic               stg10_reg, stg11_reg, stg12_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_R4])
        begin
            for (int k = 0; k < 3; k++)
                mc10_reg[k] <= mc_next[k];
            law10_reg <= carry9_reg.law;
            stg10_reg <= carry9_reg.stg;
        end
        if (adv[ST_XP])
        begin
            law11_reg <= law10_reg;
            stg11_reg <= stg10_reg;
        end
        if (adv[ST_OUT])
        begin
            law12_reg <= law11_reg;
            stg12_reg <= stg11_reg;
        end
    end

    // ---------------- pulse width scaling ----------------
    logic [15:0] pwm_ch [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_scale
        armc_scale #(
            .PWM_CENTER (PWM_CENTER),
            .FRAC_BITS  (FRAC_BITS)
        ) u_scale (
            .clk  (clk),
            .en   (adv[ST_OUT:ST_XP]),
            .mom  (mc10_reg[c]),
            .gain (cfg.gain),
            .pwm  (pwm_ch[c])
        );
    end

    assign pwm_roll       = pwm_ch[0];
    assign pwm_pitch      = pwm_ch[1];
    assign pwm_yaw        = pwm_ch[2];
    assign mode_used      = law12_reg;
    assign detumble_stage = stg12_reg;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: rate moment controller testbench
// Drives gyro items with random gaps and result stalls, predicts the three
// pulse widths, law and stage per item, and checks results in order.
// ----------------------------------------------------------------------------
module tb_top
    import armc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PWM_CENTER = 1500;
    localparam int FB         = 16;
    localparam int LATENCY    = FB + 11;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [1:0]  law;
        logic        stg;
    } pwm_out_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              sample_valid;
    logic              sample_stall;
    logic [15:0]       autopilot_pwm;
    logic signed [31:0] rate_p;
    logic signed [31:0] rate_q;
    logic signed [31:0] rate_r;
    logic              result_valid;
    logic              result_stall;
    logic [15:0]       pwm_roll;
    logic [15:0]       pwm_pitch;
    logic [15:0]       pwm_yaw;
    logic [1:0]        mode_used;
    logic              detumble_stage;

    attitude_rate_moment_controller_top u_top (.*);

    // predictor copy of the registers
    logic signed [63:0] c_mode, c_ixx, c_iyy, c_izz, c_ixy, c_ixz, c_iyz;
    logic [63:0]        c_gain;

    pwm_out_t expected_pwm[$];
    int  n_fail;
    bit  idle_enable;      // random gaps on the sender and random result stalls
    int  hold_off_cycles;  // long receiver stall request

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic signed [63:0] s32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF)
            return 64'sh7FFFFFFF;
        if (v < -64'sh80000000)
            return -64'sh80000000;
        return v;
    endfunction

    function automatic logic [63:0] magn(input logic signed [63:0] a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic [63:0] m;
        m = (magn(a) * magn(b) + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] qconst(input int n, input int d);
        return (64'(n) * (64'sd1 <<< FB) + d / 2) / d;
    endfunction

    function automatic logic signed [63:0] mq(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
        return s32(mul_round(a, b, FB));
    endfunction

    function automatic logic signed [63:0] mi(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
        return s32(mul_round(a, b, I_SH));
    endfunction

    function automatic logic [15:0] moment_to_pwm(input logic signed [63:0] m);
        logic signed [63:0] lim, v;
        lim = qconst(1, 10);
        if (m > lim) m = lim;
        if (m < -lim) m = -lim;
        v = mul_round(m, $signed(c_gain), 2 * FB) + PWM_CENTER;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic pwm_out_t predict_pwm(input logic [15:0] sw,
                                             input logic signed [31:0] rp,
                                             input logic signed [31:0] rq,
                                             input logic signed [31:0] rr);
        pwm_out_t o;
        logic signed [63:0] w[3], mo[3], g[3], iw[3], ig[3], im[3][3];
        logic signed [63:0] law, dyz, dzx, pc, qcmd, num, den;
        logic [63:0] un, ud, qm;
        logic stage;
        w[0] = rp; w[1] = rq; w[2] = rr;
        mo[0] = 0; mo[1] = 0; mo[2] = 0;
        stage = 1'b0;
        if (c_mode < 0)
            law = (sw > PWM_CENTER) ? -c_mode : 0;
        else
            law = c_mode;
        if (law > 3) law = 0;
        if (law == LAW_PROP)
        begin
            mo[0] = mq(-qconst(6, 10), w[0]);
            mo[1] = mq(-qconst(55, 100), w[1]);
            mo[2] = mq(-qconst(55, 100), w[2]);
        end
        else if (law == LAW_LIN)
        begin
            im[0][0] = c_ixx; im[1][1] = c_iyy; im[2][2] = c_izz;
            im[0][1] = c_ixy; im[1][0] = c_ixy;
            im[0][2] = c_ixz; im[2][0] = c_ixz;
            im[1][2] = c_iyz; im[2][1] = c_iyz;
            g[0] = mq(-qconst(5, 1), w[0]);
            g[1] = mq(-qconst(13, 2), w[1]);
            g[2] = mq(-qconst(12, 1), w[2]);
            for (int k = 0; k < 3; k++)
            begin
                ig[k] = s32(mi(im[k][0], g[0]) + mi(im[k][1], g[1]) + mi(im[k][2], g[2]));
                iw[k] = s32(mi(im[k][0], w[0]) + mi(im[k][1], w[1]) + mi(im[k][2], w[2]));
            end
            mo[0] = s32(ig[0] + s32(mq(w[1], iw[2]) - mq(w[2], iw[1])));
            mo[1] = s32(ig[1] + s32(mq(w[2], iw[0]) - mq(w[0], iw[2])));
            mo[2] = s32(ig[2] + s32(mq(w[0], iw[1]) - mq(w[1], iw[0])));
        end
        else if (law == LAW_TWO)
        begin
            dyz = s32(c_iyy - c_izz);
            dzx = s32(c_izz - c_ixx);
            pc = 0;
            qcmd = 0;
            if ($signed(magn(w[1])) > qconst(9, 1000) || $signed(magn(w[2])) > qconst(9, 1000))
            begin
                stage = 1'b1;
                pc = qconst(1, 2);
                num = mi(c_izz, s32(-w[2]));
                den = s32(mul_round(w[0], s32(c_ixx - c_iyy), I_SH));
                if (den == 0)
                    qcmd = num < 0 ? -(64'sd1 <<< FB) : (64'sd1 <<< FB);
                else
                begin
                    un = magn(num);
                    ud = magn(den);
                    qm = un > ud ? (64'd1 << FB) : (un << FB) / ud;
                    qcmd = ((num < 0) != (den < 0)) ? -$signed(qm) : $signed(qm);
                end
            end
            mo[0] = s32(mi(c_ixx, mq(-qconst(4, 1), s32(w[0] - pc))) - mi(dyz, mq(w[1], w[2])));
            mo[1] = s32(mi(c_iyy, mq(-qconst(2, 1), s32(w[1] - qcmd))) - mi(dzx, mq(w[0], w[2])));
        end
        if (law == LAW_NONE)
        begin
            o.roll = PWM_CENTER; o.pitch = PWM_CENTER; o.yaw = PWM_CENTER;
        end
        else
        begin
            o.roll = moment_to_pwm(mo[0]);
            o.pitch = moment_to_pwm(mo[1]);
            o.yaw = moment_to_pwm(mo[2]);
        end
        o.law = law[1:0];
        o.stg = stage;
        return o;
    endfunction

    task automatic write_reg(input armc_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = ADDR_W'(idx) << 2; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_MODE: c_mode = $signed(val[2:0]);
            REG_IXX:  c_ixx = $signed(val);
            REG_IYY:  c_iyy = $signed(val);
            REG_IZZ:  c_izz = $signed(val);
            REG_IXY:  c_ixy = $signed(val);
            REG_IXZ:  c_ixz = $signed(val);
            REG_IYZ:  c_iyz = $signed(val);
            REG_GAIN: c_gain = val;
            default: ;
        endcase
    endtask

    // one item; called right after a falling edge
    task automatic send_sample(input logic [15:0] sw, input logic signed [31:0] rp,
                               input logic signed [31:0] rq, input logic signed [31:0] rr);
        if (idle_enable)
            while ($urandom_range(99) < 23) @(negedge clk);
        sample_valid = 1'b1;
        autopilot_pwm = sw; rate_p = rp; rate_q = rq; rate_r = rr;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        expected_pwm.push_back(predict_pwm(sw, rp, rq, rr));
        @(negedge clk);
        sample_valid = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_pwm.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_rate();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1200)) - 600);          // near thresholds
            2: return 32'($signed($urandom_range(1 << 19)) - (1 << 18)); // +-4 rad/s
            3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rnd_inertia();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1 << 26);       // realistic small body
            2: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
            default: return $urandom_range(1 << 30);
        endcase
    endfunction

    task automatic randomize_regs();
        write_reg(REG_IXX, rnd_inertia());
        write_reg(REG_IYY, rnd_inertia());
        write_reg(REG_IZZ, rnd_inertia());
        write_reg(REG_IXY, rnd_inertia());
        write_reg(REG_IXZ, rnd_inertia());
        write_reg(REG_IYZ, rnd_inertia());
        write_reg(REG_GAIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 28));
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_sample($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1000, 2000)),
                        rnd_rate(), rnd_rate(), rnd_rate());
    endtask

    task automatic test_directed();
        logic signed [31:0] ext[4];
        ext[0] = 32'h7FFFFFFF; ext[1] = 32'h80000000; ext[2] = 0; ext[3] = 32'h00000253;
        write_reg(REG_IXX, 32'h7FFFFFFF);
        write_reg(REG_IYY, 32'h80000000);
        write_reg(REG_IZZ, 32'h01000000);
        write_reg(REG_IXY, 32'h00100000);
        write_reg(REG_IXZ, 32'hFFF00000);
        write_reg(REG_IYZ, 32'h00000000);
        write_reg(REG_GAIN, 32'hFFFFFFFF);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_MODE, 32'(m));
            for (int k = 0; k < 4; k++)
                send_sample(16'hFFFF, ext[k], ext[(k + 1) % 4], ext[(k + 2) % 4]);
            drain();
        end
        // zero divisor: equal xx and yy inertia in stage one
        write_reg(REG_MODE, 32'd3);
        write_reg(REG_IYY, 32'h7FFFFFFF);
        send_sample(16'd0, 32'h00010000, 32'h00010000, 32'h00010000);
        send_sample(16'd0, 32'h00010000, 32'h00010000, 32'hFFFF0000);
        drain();
        // unknown law and switch gating
        write_reg(REG_MODE, 32'h4);
        send_sample(16'hFFFF, 32'h00010000, 32'h0, 32'h0);
        drain();
        write_reg(REG_MODE, 32'h5);
        send_sample(16'd1500, 32'h00010000, 32'h0, 32'h0);
        send_sample(16'd1501, 32'h00010000, 32'h0, 32'h0);
        send_sample(16'd0, 32'h00010000, 32'h0, 32'h0);
        drain();
    endtask

    task automatic test_modes_random();
        for (int ph = 0; ph < 14; ph++)
        begin
            write_reg(REG_MODE, 32'($urandom_range(7)));
            randomize_regs();
            idle_enable = (ph != 5);
            send_random(100);
            drain();
        end
        idle_enable = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODE, 32'd2);
        hold_off_cycles = 200;
        idle_enable = 1'b0;
        send_random(120);
        idle_enable = 1'b1;
        drain();
        // sender pauses until all results are in, then resumes
        send_random(50);
        drain();
        write_reg(REG_MODE, 32'd3);
        send_random(50);
        drain();
    endtask

    // result stall generator
    initial
    begin
        result_stall = 1'b0;
        hold_off_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                result_stall = 1'b1;
                hold_off_cycles--;
            end
            else
                result_stall = idle_enable && ($urandom_range(99) < 23);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        pwm_out_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_pwm.size() == 0)
            begin
                $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d",
                         $time, pwm_roll, pwm_pitch, pwm_yaw);
                n_fail++;
            end
            else
            begin
                e = expected_pwm.pop_front();
                if (pwm_roll !== e.roll)
                begin
                    $display("%0t: pwm_roll exp %0d got %0d", $time, e.roll, pwm_roll);
                    n_fail++;
                end
                if (pwm_pitch !== e.pitch)
                begin
                    $display("%0t: pwm_pitch exp %0d got %0d", $time, e.pitch, pwm_pitch);
                    n_fail++;
                end
                if (pwm_yaw !== e.yaw)
                begin
                    $display("%0t: pwm_yaw exp %0d got %0d", $time, e.yaw, pwm_yaw);
                    n_fail++;
                end
                if (mode_used !== e.law)
                begin
                    $display("%0t: mode_used exp %0d got %0d", $time, e.law, mode_used);
                    n_fail++;
                end
                if (detumble_stage !== e.stg)
                begin
                    $display("%0t: detumble_stage exp %0d got %0d", $time, e.stg,
                             detumble_stage);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        n_fail = 0;
        idle_enable = 1'b1;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        sample_valid = 1'b0;
        autopilot_pwm = '0; rate_p = '0; rate_q = '0; rate_r = '0;
        c_mode = 0; c_ixx = 0; c_iyy = 0; c_izz = 0;
        c_ixy = 0; c_ixz = 0; c_iyz = 0; c_gain = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_modes_random();
        test_backpressure();
        drain();
        if (n_fail == 0 && expected_pwm.size() == 0)
            $display("tb_top: PASS");
        else
        begin
            if (expected_pwm.size() != 0)
                $display("%0t: %0d results never arrived", $time, expected_pwm.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
